/* sv/assert_macros.svh */
// Assertion macros shared by the averager RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every rising clock edge outside reset.
`define PTA_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("pta assertion failed");
// Expression must never be true outside reset.
`define PTA_ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
    else $error("pta forbidden condition seen");
`else
`define PTA_ASSERT(lbl, clk_s, rstn_s, prop)
`define PTA_ASSERT_NEVER(lbl, clk_s, rstn_s, expr)
`endif
`endif

/* sv/pta_pkg.sv */
// Package of the periodic three-axis averager: widths, reset values,
// register indexes and the control and status structs passed between its modules.
package pta_pkg;

  // Field widths.
  localparam int SAMPLE_BITS   = 24;
  localparam int ELAPSED_BITS  = 16;
  localparam int PERIOD_BITS   = 16;
  localparam int GUARD_BITS    = 8;
  localparam int RESYNC_BITS   = 4;
  localparam int CNT_BITS      = 10;
  localparam int TIMER_BITS    = 20;
  localparam int SUM_BITS      = 34;
  localparam int MAX_COUNT     = 1023;

  // Serial datapath shape.
  localparam int DIGIT_BITS    = 2;
  localparam int ACC_STEPS     = SUM_BITS / DIGIT_BITS;
  localparam int ACC_STEP_BITS = $clog2(ACC_STEPS);
  localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);

  // Configuration port.
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_GUARD  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RESYNC = 2'd2;

  // Register reset values.
  localparam logic [PERIOD_BITS-1:0] PERIOD_RST = 16'd1000;
  localparam logic [GUARD_BITS-1:0]  GUARD_RST  = 8'd20;
  localparam logic [RESYNC_BITS-1:0] RESYNC_RST = 4'd5;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;

  // Control of one serial axis accumulator.
  typedef struct packed {
    logic load;
    logic step;
    logic clear;
  } acc_ctrl_t;

  // Status of the shared serial divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* sv/pta_if.sv */
// Valid/ready channel interfaces for the averager's input and result items.
// Depends on pta_pkg for field widths and types.
interface pta_in_if;
  import pta_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ELAPSED_BITS-1:0] elapsed_ms;
  logic                    sample_valid;
  logic                    read_failed;
  sample_t                 field_x;
  sample_t                 field_y;
  sample_t                 field_z;

  modport source (output valid, elapsed_ms, sample_valid, read_failed,
                  field_x, field_y, field_z, input ready);
  modport sink   (input valid, elapsed_ms, sample_valid, read_failed,
                  field_x, field_y, field_z, output ready);
endinterface

interface pta_out_if;
  import pta_pkg::*;

  logic                valid;
  logic                ready;
  sample_t             avg_x;
  sample_t             avg_y;
  sample_t             avg_z;
  logic [CNT_BITS-1:0] sample_count;
  logic                saturation_flag;

  modport source (output valid, avg_x, avg_y, avg_z, sample_count,
                  saturation_flag, input ready);
  modport sink   (input valid, avg_x, avg_y, avg_z, sample_count,
                  saturation_flag, output ready);
endinterface

/* sv/pta_axis_acc.sv */
// One axis running sum, added DIGIT_BITS bits per cycle while step is set, with a serial adder.
// Depends on pta_pkg.
module pta_axis_acc (
  input  logic                clk,
  input  logic                rst_n,
  input  pta_pkg::acc_ctrl_t  ctrl,
  input  pta_pkg::sample_t    sample,
  output pta_pkg::sum_t       sum
);
  import pta_pkg::*;

  logic [SUM_BITS-1:0]   sum_r;
  logic [SUM_BITS-1:0]   addend_r;
  logic                  carry_r;
  logic [DIGIT_BITS:0]   digit_sum;

  // One digit of the sum plus the carry out of it.
  assign digit_sum = {1'b0, sum_r[DIGIT_BITS-1:0]} + {1'b0, addend_r[DIGIT_BITS-1:0]}
                   + {{DIGIT_BITS{1'b0}}, carry_r};

  // The sum rotates right one digit a step; after a full turn it is aligned again.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      carry_r <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        sum_r <= '0;
      end else if (ctrl.step) begin
        sum_r <= {digit_sum[DIGIT_BITS-1:0], sum_r[SUM_BITS-1:DIGIT_BITS]};
      end
      if (ctrl.load) begin
        carry_r <= 1'b0;
      end else if (ctrl.step) begin
        carry_r <= digit_sum[DIGIT_BITS];
      end
    end
  end

  // The addend is the sign-extended sample, shifted out one digit a step.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      addend_r <= {{(SUM_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    end else if (ctrl.step) begin
      addend_r <= addend_r >> DIGIT_BITS;
    end
  end

  assign sum = sum_t'(sum_r);

endmodule

/* sv/pta_divider.sv */
// Shared bit-serial restoring divider: signed sum over unsigned count,
// truncated toward zero, one quotient bit per cycle. Depends on pta_pkg.
module pta_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  pta_pkg::sum_t                 dividend,
  input  logic [pta_pkg::CNT_BITS-1:0]  divisor,
  output pta_pkg::div_stat_t            stat,
  output pta_pkg::sample_t              quotient
);
  import pta_pkg::*;

  logic [SUM_BITS-1:0]     num_r;
  logic [CNT_BITS-1:0]     rem_r;
  logic                    neg_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    busy_r;
  logic                    done_r;

  logic [SUM_BITS-1:0]     dividend_u;
  logic [SUM_BITS-1:0]     mag;
  logic [CNT_BITS:0]       trial;
  logic [CNT_BITS:0]       diff;
  logic                    fits;
  logic [SAMPLE_BITS-1:0]  q_mag;

  // Work on the magnitude; the sign is put back at the end.
  assign dividend_u = dividend;
  assign mag        = dividend_u[SUM_BITS-1] ? -dividend_u : dividend_u;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_r, num_r[SUM_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_BITS'(SUM_BITS-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient bits replace dividend bits in the same shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= mag;
      rem_r <= '0;
      neg_r <= dividend_u[SUM_BITS-1];
    end else if (busy_r) begin
      num_r <= {num_r[SUM_BITS-2:0], fits};
      rem_r <= fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
    end
  end

  assign q_mag       = num_r[SAMPLE_BITS-1:0];
  assign quotient    = neg_r ? sample_t'(-q_mag) : sample_t'(q_mag);
  assign stat.busy   = busy_r;
  assign stat.done   = done_r;

endmodule

/* sv/periodic_three_axis_averager_core.sv */
// Periodic three-axis averager, top level: control sequencer, registers,
// output stage. Depends on pta_pkg, pta_if, pta_axis_acc, pta_divider.
//
// Each accepted item updates the guard window and the period timer. A sample
// that is taken is added into the three axis sums by 2-bit serial adders,
// and a last accumulate step without an add lets the sums settle before a
// division may start. When the period closes with samples, one shared
// bit-serial divider forms the three means in turn, each from 34 quotient
// bits. The result item is then loaded into the output register once that
// register is free, and the period state is cleared in the next cycle. An
// item that closes a period with samples thus also waits for any earlier
// result in the output register to be taken. The input is accepted again
// as soon as that work is done, while a result may still wait at the
// output.
`include "assert_macros.svh"

module periodic_three_axis_averager_core (
  input  logic                              clk,
  input  logic                              rst_n,
  pta_in_if.sink                            in_ch,
  pta_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pta_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pta_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import pta_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACC   = 5'b00010,
    S_DIV   = 5'b00100,
    S_EMIT  = 5'b01000,
    S_CLOSE = 5'b10000
  } state_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  state_t                   state_r, state_nxt;
  logic [PERIOD_BITS-1:0]   period_ms_r;
  logic [GUARD_BITS-1:0]    guard_ms_r;
  logic [RESYNC_BITS-1:0]   resync_r;
  logic [GUARD_BITS-1:0]    guard_left_r;
  logic [TIMER_BITS-1:0]    period_elapsed_r;
  logic [CNT_BITS-1:0]      taken_count_r;
  logic                     failed_mark_r;
  logic                     close_r;
  logic [ACC_STEP_BITS-1:0] step_r;
  logic [1:0]               axis_r;
  sample_t                  avg_x_hold_r;
  sample_t                  avg_y_hold_r;

  logic                     out_valid_r;
  sample_t                  out_avg_x_r;
  sample_t                  out_avg_y_r;
  sample_t                  out_avg_z_r;
  logic [CNT_BITS-1:0]      out_count_r;
  logic                     out_flag_r;

  logic                     in_acc;
  logic [GUARD_BITS-1:0]    guard_after;
  logic                     guard_open;
  logic                     take;
  logic                     mark_now;
  logic [TIMER_BITS:0]      timer_sum;
  logic [TIMER_BITS-1:0]    timer_sat;
  logic                     close_now;
  logic                     acc_last;
  logic                     out_free;
  logic [TIMER_BITS-1:0]    timer_sub;
  logic [TIMER_BITS-1:0]    resync_limit;

  acc_ctrl_t                acc_ctrl;
  sum_t                     sum_x, sum_y, sum_z;
  logic                     div_start;
  logic [1:0]               start_axis;
  sum_t                     div_dividend;
  div_stat_t                div_stat;
  sample_t                  div_quot;

  // Accept-cycle decisions: guard window, sample take and period timer.
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign guard_after = (in_ch.elapsed_ms >= ELAPSED_BITS'(guard_left_r)) ? '0
                     : guard_left_r - in_ch.elapsed_ms[GUARD_BITS-1:0];
  assign guard_open  = (guard_after == '0);
  assign mark_now    = guard_open && in_ch.read_failed;
  assign take        = guard_open && !in_ch.read_failed && in_ch.sample_valid
                    && (taken_count_r < CNT_BITS'(MAX_COUNT));
  assign timer_sum   = {1'b0, period_elapsed_r} + (TIMER_BITS+1)'(in_ch.elapsed_ms);
  assign timer_sat   = timer_sum[TIMER_BITS] ? '1 : timer_sum[TIMER_BITS-1:0];
  assign close_now   = timer_sat >= TIMER_BITS'(period_ms_r);
  // The last accumulate cycle does no step, so the sums are aligned in it.
  assign acc_last    = (step_r == ACC_STEP_BITS'(ACC_STEPS));
  assign out_free    = !out_valid_r || out_ch.ready;

  // Period close arithmetic: subtract one period, restart on excess lag.
  assign timer_sub    = period_elapsed_r - TIMER_BITS'(period_ms_r);
  assign resync_limit = TIMER_BITS'(period_ms_r) * TIMER_BITS'(resync_r);

  // Serial accumulators, one per axis.
  assign acc_ctrl.load  = in_acc;
  assign acc_ctrl.step  = (state_r == S_ACC) && !acc_last;
  assign acc_ctrl.clear = (state_r == S_CLOSE);

  pta_axis_acc u_acc_x (.clk(clk), .rst_n(rst_n), .ctrl(acc_ctrl),
                        .sample(in_ch.field_x), .sum(sum_x));
  pta_axis_acc u_acc_y (.clk(clk), .rst_n(rst_n), .ctrl(acc_ctrl),
                        .sample(in_ch.field_y), .sum(sum_y));
  pta_axis_acc u_acc_z (.clk(clk), .rst_n(rst_n), .ctrl(acc_ctrl),
                        .sample(in_ch.field_z), .sum(sum_z));

  // Divider starts: first axis on entry to the division, next axis on done.
  assign div_start = (in_acc && !take && close_now && (taken_count_r != '0))
                  || ((state_r == S_ACC) && acc_last && close_r)
                  || ((state_r == S_DIV) && div_stat.done && (axis_r != AXIS_Z));
  assign start_axis = (state_r == S_DIV) ? axis_r + 2'd1 : AXIS_X;

  always_comb begin
    case (start_axis)
      AXIS_X:  div_dividend = sum_x;
      AXIS_Y:  div_dividend = sum_y;
      default: div_dividend = sum_z;
    endcase
  end

  pta_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_start),
                     .dividend(div_dividend), .divisor(taken_count_r),
                     .stat(div_stat), .quotient(div_quot));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (take) begin
            state_nxt = S_ACC;
          end else if (close_now) begin
            state_nxt = (taken_count_r != '0) ? S_DIV : S_CLOSE;
          end
        end
      end
      S_ACC: begin
        if (acc_last) begin
          state_nxt = close_r ? S_DIV : S_IDLE;
        end
      end
      S_DIV: begin
        if (div_stat.done && (axis_r == AXIS_Z)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_CLOSE;
        end
      end
      S_CLOSE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and period state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      period_ms_r      <= PERIOD_RST;
      guard_ms_r       <= GUARD_RST;
      resync_r         <= RESYNC_RST;
      guard_left_r     <= '0;
      period_elapsed_r <= '0;
      taken_count_r    <= '0;
      failed_mark_r    <= 1'b0;
      close_r          <= 1'b0;
      step_r           <= '0;
      axis_r           <= AXIS_X;
      out_valid_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Configuration writes.
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD: period_ms_r <= cfg_wdata[PERIOD_BITS-1:0];
          REG_GUARD:  guard_ms_r  <= cfg_wdata[GUARD_BITS-1:0];
          REG_RESYNC: resync_r    <= cfg_wdata[RESYNC_BITS-1:0];
          default: ;
        endcase
      end

      // Item accept.
      if (in_acc) begin
        guard_left_r     <= guard_after;
        period_elapsed_r <= timer_sat;
        close_r          <= close_now;
        step_r           <= '0;
        axis_r           <= AXIS_X;
        if (mark_now) begin
          failed_mark_r <= 1'b1;
        end
        if (take) begin
          taken_count_r <= taken_count_r + 1'b1;
        end
      end

      if (state_r == S_ACC) begin
        step_r <= step_r + 1'b1;
      end

      if ((state_r == S_DIV) && div_stat.done) begin
        axis_r <= axis_r + 2'd1;
      end

      // Output register: loaded from the emit step, freed when taken.
      if ((state_r == S_EMIT) && out_free) begin
        out_valid_r  <= 1'b1;
        guard_left_r <= guard_ms_r;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // Period close: clear the period state and step the timer.
      if (state_r == S_CLOSE) begin
        taken_count_r    <= '0;
        failed_mark_r    <= 1'b0;
        period_elapsed_r <= (timer_sub > resync_limit) ? '0 : timer_sub;
      end
    end
  end

  // Quotient holding and result payload.
  always_ff @(posedge clk) begin
    if ((state_r == S_DIV) && div_stat.done) begin
      case (axis_r)
        AXIS_X:  avg_x_hold_r <= div_quot;
        AXIS_Y:  avg_y_hold_r <= div_quot;
        default: ;
      endcase
    end
    if ((state_r == S_EMIT) && out_free) begin
      out_avg_x_r <= avg_x_hold_r;
      out_avg_y_r <= avg_y_hold_r;
      out_avg_z_r <= div_quot;
      out_count_r <= taken_count_r;
      out_flag_r  <= failed_mark_r;
    end
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.avg_x           = out_avg_x_r;
  assign out_ch.avg_y           = out_avg_y_r;
  assign out_ch.avg_z           = out_avg_z_r;
  assign out_ch.sample_count    = out_count_r;
  assign out_ch.saturation_flag = out_flag_r;

  // A new result only appears out of the emit step.
  `PTA_ASSERT(a_emit_source, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_EMIT))
  // A result never reports an empty period.
  `PTA_ASSERT(a_count_nonzero, clk, rst_n, out_valid_r |-> (out_count_r != '0))
  // The shared divider is never restarted while it is still working.
  `PTA_ASSERT_NEVER(a_div_overlap, clk, rst_n, div_start && div_stat.busy)
  // The division only runs with a nonzero count.
  `PTA_ASSERT(a_div_divisor, clk, rst_n, div_start |-> (taken_count_r != '0))

endmodule

/* dv/pta_mean_check.sv */
// Checker for the periodic three-axis averager: follows both channels and the register
// port, predicts every averaged result, and compares it field by field.
// Depends on pta_pkg and on the channel interfaces in pta_if.
module pta_mean_check
  import pta_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  pta_in_if                        in_mon,
  pta_out_if                       out_mon,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
  output int                       mismatch_count,
  output int                       means_pending,
  output int                       means_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMER_MAX = (1 << TIMER_BITS) - 1;

  typedef struct {
    sample_t             avg_x;
    sample_t             avg_y;
    sample_t             avg_z;
    logic [CNT_BITS-1:0] count;
    logic                flag;
  } mean_item_t;

  // Register copies.
  int unsigned period_cfg;
  int unsigned guard_cfg;
  int unsigned resync_cfg;

  // Accumulation state of the open period.
  longint      acc_x;
  longint      acc_y;
  longint      acc_z;
  int unsigned n_taken;
  int unsigned ms_in_period;
  int unsigned guard_ms_left;
  logic        fail_seen;

  // Means predicted but not yet seen on the result channel, oldest first.
  mean_item_t  pending_means[$];

  // Advances the averager by one input item; returns 1 when the item closes a
  // period that holds samples, with the means in mean.
  function automatic bit step_averager(input logic [ELAPSED_BITS-1:0] elapsed,
                                       input logic good, input logic bad,
                                       input sample_t x, input sample_t y,
                                       input sample_t z, output mean_item_t mean);
    int unsigned span;
    bit          made;
    made = 1'b0;
    mean = '{default: '0};

    // The guard window runs down first, then the item may be taken.
    guard_ms_left = (elapsed >= guard_ms_left) ? 0 : guard_ms_left - elapsed;
    if (guard_ms_left == 0) begin
      if (bad) begin
        fail_seen = 1'b1;
      end else if (good && n_taken < MAX_COUNT) begin
        acc_x += longint'(x);
        acc_y += longint'(y);
        acc_z += longint'(z);
        n_taken++;
      end
    end

    // The period timer saturates rather than wrapping.
    span = ms_in_period + elapsed;
    if (span > TIMER_MAX) span = TIMER_MAX;
    ms_in_period = span;

    // Close the period; only a period with samples produces an item.
    if (ms_in_period >= period_cfg) begin
      if (n_taken >= 1) begin
        mean.avg_x = sample_t'(acc_x / longint'(n_taken));
        mean.avg_y = sample_t'(acc_y / longint'(n_taken));
        mean.avg_z = sample_t'(acc_z / longint'(n_taken));
        mean.count = CNT_BITS'(n_taken);
        mean.flag  = fail_seen;
        made = 1'b1;
        guard_ms_left = guard_cfg;
      end
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      n_taken = 0;
      fail_seen = 1'b0;
      ms_in_period -= period_cfg;
      if (longint'(ms_in_period) > longint'(resync_cfg) * longint'(period_cfg)) begin
        ms_in_period = 0;
      end
    end
    return made;
  endfunction

  function automatic void check_field(string name, logic [SAMPLE_BITS-1:0] want,
                                      logic [SAMPLE_BITS-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // All bookkeeping happens on the rising edge, where the block samples too.
  always @(posedge clk) begin
    mean_item_t want;
    mean_item_t made;
    if (!rst_n) begin
      period_cfg     = PERIOD_RST;
      guard_cfg      = GUARD_RST;
      resync_cfg     = RESYNC_RST;
      acc_x          = 0;
      acc_y          = 0;
      acc_z          = 0;
      n_taken        = 0;
      ms_in_period   = 0;
      guard_ms_left  = 0;
      fail_seen      = 1'b0;
      mismatch_count = 0;
      means_checked  = 0;
      pending_means.delete();
    end else begin
      // Register writes take effect at the edge that carries them.
      if (cfg_we) begin
        case (cfg_index)
          REG_PERIOD: period_cfg = cfg_wdata[PERIOD_BITS-1:0];
          REG_GUARD:  guard_cfg  = cfg_wdata[GUARD_BITS-1:0];
          REG_RESYNC: resync_cfg = cfg_wdata[RESYNC_BITS-1:0];
          default: ;
        endcase
      end

      // Each accepted result is matched against the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        if (pending_means.size() == 0) begin
          $display("%0t: result with none expected, actual %h %h %h count %0d flag %b",
                   $time, out_mon.avg_x, out_mon.avg_y, out_mon.avg_z,
                   out_mon.sample_count, out_mon.saturation_flag);
          mismatch_count++;
        end else begin
          want = pending_means.pop_front();
          check_field("avg_x", want.avg_x, out_mon.avg_x);
          check_field("avg_y", want.avg_y, out_mon.avg_y);
          check_field("avg_z", want.avg_z, out_mon.avg_z);
          check_field("sample_count", SAMPLE_BITS'(want.count),
                      SAMPLE_BITS'(out_mon.sample_count));
          check_field("saturation_flag", SAMPLE_BITS'(want.flag),
                      SAMPLE_BITS'(out_mon.saturation_flag));
          means_checked++;
        end
      end

      // Each accepted input item advances the prediction.
      if (in_mon.valid && in_mon.ready) begin
        if (step_averager(in_mon.elapsed_ms, in_mon.sample_valid, in_mon.read_failed,
                          in_mon.field_x, in_mon.field_y, in_mon.field_z, made)) begin
          pending_means.push_back(made);
        end
      end
    end
    means_pending = pending_means.size();
  end

endmodule

/* dv/tb_periodic_three_axis_averager_core.sv */
// Testbench top of the periodic three-axis averager: clock, reset, register setup,
// input stimulus and result back-pressure, with the verdict from pta_mean_check.
// Depends on pta_pkg, pta_if, the averager RTL and dv/pta_mean_check.sv.
module tb_periodic_three_axis_averager_core
  import pta_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF         = 4;
  localparam int CLK_PERIOD       = 2 * CLK_HALF;
  localparam int RESET_CYCLES     = 9;
  localparam int RUN_LIMIT_CYCLES = 2_500_000;
  localparam int SETTLE_CYCLES    = 150;
  localparam int HOLD_CYCLES      = 1500;
  localparam int PHASE_ITEMS      = 95;
  localparam int FILL_ITEMS       = 1060;
  localparam int PRESSURE_ITEMS   = 10;

  // Index 3 has no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_STALL_RUNS} rx_mode_t;

  typedef struct {
    logic [ELAPSED_BITS-1:0] elapsed;
    logic                    good;
    logic                    bad;
    sample_t                 x;
    sample_t                 y;
    sample_t                 z;
  } mag_item_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  int   mismatch_count;
  int   means_pending;
  int   means_checked;

  int   items_sent = 0;
  int   settings_used = 0;
  int   burst_left = 0;
  int   hold_asks = 0;
  logic rx_holding = 1'b0;

  pta_in_if  in_ch ();
  pta_out_if out_ch ();

  periodic_three_axis_averager_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pta_mean_check mean_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .means_pending  (means_pending),
    .means_checked  (means_checked)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(RUN_LIMIT_CYCLES * CLK_PERIOD);
    $display("tb_periodic_three_axis_averager_core NOT OK");
    $finish;
  end

  function automatic mag_item_t make_item(int unsigned elapsed, logic good, logic bad,
                                          sample_t x, sample_t y, sample_t z);
    mag_item_t it;
    it.elapsed = elapsed[ELAPSED_BITS-1:0];
    it.good = good;
    it.bad = bad;
    it.x = x;
    it.y = y;
    it.z = z;
    return it;
  endfunction

  // Axis value with the extremes favored.
  function automatic sample_t rand_axis();
    case ($urandom_range(0, 15))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return '0;
      3: return '1;
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Random item; elapsed time is scaled to the period so that periods close
  // often, with some long jumps that trigger the lag restart.
  function automatic mag_item_t rand_item(int unsigned period);
    mag_item_t   it;
    int unsigned pick;
    int unsigned wide;
    pick = $urandom_range(0, 99);
    wide = (2 * period > 65535) ? 65535 : 2 * period;
    if (pick < 15) it.elapsed = '0;
    else if (pick < 65) it.elapsed = ELAPSED_BITS'($urandom_range(0, period / 4 + 1));
    else if (pick < 85) it.elapsed = ELAPSED_BITS'($urandom_range(0, wide));
    else if (pick < 93) it.elapsed = ELAPSED_BITS'($urandom());
    else it.elapsed = '1;
    it.good = ($urandom_range(0, 3) != 0);
    it.bad = ($urandom_range(0, 15) == 0);
    it.x = rand_axis();
    it.y = rand_axis();
    it.z = rand_axis();
    return it;
  endfunction

  // Presents one item from a falling edge and holds it until accepted.
  task automatic push_item(input mag_item_t it);
    in_ch.valid = 1'b1;
    in_ch.elapsed_ms = it.elapsed;
    in_ch.sample_valid = it.good;
    in_ch.read_failed = it.bad;
    in_ch.field_x = it.x;
    in_ch.field_y = it.y;
    in_ch.field_z = it.z;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  // Sends in bursts of random length, with random gaps between bursts.
  task automatic offer_item(input mag_item_t it);
    int gap;
    int pick;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) gap = $urandom_range(20, 150);
      else if (pick < 4) gap = 0;
      else gap = $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    push_item(it);
  endtask

  // Stops sending, waits for every predicted result, then lets any item that
  // closed an empty period finish its work.
  task automatic drain_block();
    in_ch.valid = 1'b0;
    wait (means_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all registers while the block is idle; upper data bits of the guard and resync writes carry noise.
  task automatic apply_setting(int unsigned period, int unsigned guard, int unsigned resync);
    drain_block();
    cfg_we = 1'b1;
    cfg_index = REG_PERIOD;
    cfg_wdata = period[PERIOD_BITS-1:0];
    @(negedge clk);
    cfg_index = REG_GUARD;
    cfg_wdata = {8'($urandom()), guard[GUARD_BITS-1:0]};
    @(negedge clk);
    cfg_index = REG_RESYNC;
    cfg_wdata = {12'($urandom()), resync[RESYNC_BITS-1:0]};
    @(negedge clk);
    cfg_index = REG_SPARE;
    cfg_wdata = 16'($urandom());
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  task automatic run_random_phase(int items, int unsigned period);
    repeat (items) offer_item(rand_item(period));
  endtask

  // Result side: stall patterns that change now and then, plus one long
  // hold-off on request.
  initial begin
    rx_mode_t mode;
    int       mode_left;
    int       stall_left;
    int       tick;
    int       hold_left;
    int       hold_seen;
    out_ch.ready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    stall_left = 0;
    tick = 0;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rx_holding = 1'b1;
        out_ch.ready = 1'b0;
      end else begin
        rx_holding = 1'b0;
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        case (mode)
          RX_OPEN: out_ch.ready = 1'b1;
          RX_COIN: out_ch.ready = 1'($urandom_range(0, 1));
          RX_EVERY_FOURTH: out_ch.ready = (tick % 4 == 0);
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              out_ch.ready = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
              stall_left = $urandom_range(1, 15);
              out_ch.ready = 1'b0;
            end else begin
              out_ch.ready = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Main sequence: directed items, random phases over several settings, a
  // full sample count, output back-pressure, then the verdict.
  initial begin
    int unsigned plan_period[6];
    int unsigned plan_guard[6];
    int unsigned plan_resync[6];
    int unsigned rnd_period;
    mag_item_t   it;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PERIOD;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.elapsed_ms = '0;
    in_ch.sample_valid = 1'b0;
    in_ch.read_failed = 1'b0;
    in_ch.field_x = '0;
    in_ch.field_y = '0;
    in_ch.field_z = '0;
    plan_period = '{37, 4000, 65535, 250, 1, 12};
    plan_guard  = '{5, 255, 0, 100, 0, 3};
    plan_resync = '{3, 15, 15, 1, 1, 8};

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: a two-sample period of opposite extremes, a sample
    // lost in the guard window, then a failure that marks the next period.
    offer_item(make_item(500, 1'b1, 1'b0, SAMPLE_MAX, SAMPLE_MIN, -1));
    offer_item(make_item(500, 1'b1, 1'b0, SAMPLE_MIN, SAMPLE_MAX, 0));
    offer_item(make_item(19, 1'b1, 1'b0, 5, 5, 5));
    offer_item(make_item(1, 1'b1, 1'b0, 7, -7, 3));
    offer_item(make_item(0, 1'b0, 1'b1, 1, 1, 1));
    offer_item(make_item(999, 1'b0, 1'b0, 0, 0, 0));

    // Short period: failure beating a sample, truncation toward zero,
    // guard window, an empty period and lag restarts.
    apply_setting(100, 10, 2);
    offer_item(make_item(20, 1'b0, 1'b0, 0, 0, 0));
    offer_item(make_item(0, 1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
    offer_item(make_item(0, 1'b1, 1'b0, -7, 7, SAMPLE_MIN));
    offer_item(make_item(0, 1'b1, 1'b0, -1, 8, SAMPLE_MIN));
    offer_item(make_item(61, 1'b1, 1'b0, 0, 0, 0));
    offer_item(make_item(4, 1'b0, 1'b1, 0, 0, 0));
    offer_item(make_item(5, 1'b1, 1'b0, 9, 9, 9));
    offer_item(make_item(1, 1'b1, 1'b0, -3, 4, -5));
    offer_item(make_item(200, 1'b0, 1'b0, 0, 0, 0));
    offer_item(make_item(65535, 1'b0, 1'b0, 0, 0, 0));
    offer_item(make_item(65535, 1'b1, 1'b0, SAMPLE_MIN, SAMPLE_MAX, 1));
    offer_item(make_item(0, 1'b0, 1'b0, 0, 0, 0));

    // Random phases over a spread of settings, extremes included.
    foreach (plan_period[i]) begin
      apply_setting(plan_period[i], plan_guard[i], plan_resync[i]);
      run_random_phase(PHASE_ITEMS, plan_period[i]);
    end

    // Longest period with more samples than the count can hold; the first
    // item clears any guard window left from the previous phase.
    apply_setting(65535, 0, 15);
    offer_item(make_item(255, 1'b1, 1'b0, rand_axis(), rand_axis(), rand_axis()));
    for (int k = 0; k < FILL_ITEMS; k++) begin
      it = make_item((k % 50 == 49) ? 1 : 0, 1'b1, ($urandom_range(0, 99) == 0),
                     rand_axis(), rand_axis(), rand_axis());
      offer_item(it);
    end
    offer_item(make_item(65535, 1'b1, 1'b0, rand_axis(), rand_axis(), rand_axis()));

    // Every item closes a period while the result side holds off, so the
    // block fills up and stops taking input.
    apply_setting(1, 0, 15);
    hold_asks++;
    wait (rx_holding);
    @(negedge clk);
    repeat (PRESSURE_ITEMS) begin
      push_item(make_item(1, 1'b1, 1'b0, rand_axis(), rand_axis(), rand_axis()));
    end
    drain_block();

    // One last random setting.
    rnd_period = $urandom_range(1, 65535);
    apply_setting(rnd_period, $urandom_range(0, 255), $urandom_range(1, 15));
    run_random_phase(PHASE_ITEMS, rnd_period);

    drain_block();
    $display("Summary: %0d items over %0d register settings, covering guard windows,",
             items_sent, settings_used);
    $display("lag restarts, a full sample count and a held-off output; %0d results checked.",
             means_checked);
    if (mismatch_count == 0 && means_pending == 0) begin
      $display("tb_periodic_three_axis_averager_core OK");
    end else begin
      $display("tb_periodic_three_axis_averager_core NOT OK");
    end
    $finish;
  end

endmodule

/* periodic_three_axis_averager_core.f */
+incdir+sv
sv/pta_pkg.sv
sv/pta_if.sv
sv/pta_axis_acc.sv
sv/pta_divider.sv
sv/periodic_three_axis_averager_core.sv
dv/pta_mean_check.sv
dv/tb_periodic_three_axis_averager_core.sv
